// ===== rtl/core/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW = 5;

  typedef enum logic [FuncW-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_REAR  = 3'd1,
    FN_DEL_FRONT = 3'd2,
    FN_DEL_REAR  = 3'd3,
    FN_LIST      = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_LISTED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     rear_slot;
    logic     tail;
  } cell_ctrl_t;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] value_in;
  } deq_in_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] value_out;
    logic [FillW-1:0]        fill;
    logic                    last;
  } deq_out_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the queue chain.
module deq_cell (
  input  logic                              clk_i,
  input  deq_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [deq_pkg::DataW-1:0]  left_i,
  input  logic signed [deq_pkg::DataW-1:0]  right_i,
  input  logic signed [deq_pkg::DataW-1:0]  ins_i,
  input  logic signed [deq_pkg::DataW-1:0]  head_i,
  output logic signed [deq_pkg::DataW-1:0]  data_o
);

  logic signed [deq_pkg::DataW-1:0] data_q;
  logic signed [deq_pkg::DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      deq_pkg::OP_PUSH_FRONT: data_d = left_i;
      deq_pkg::OP_PUSH_REAR: begin
        if (ctrl_i.rear_slot) data_d = ins_i;
      end
      deq_pkg::OP_POP_FRONT: data_d = right_i;
      deq_pkg::OP_ROTATE: data_d = ctrl_i.tail ? head_i : right_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Double-ended queue top level: control and the chain of storage cells.
// Insert, delete and unused codes: result in the cycle after acceptance, one item per cycle while not busy listing.
// Listing of n elements: n results, one per cycle, from the cycle after acceptance;
// busy_o is high in the listing state, while the occupied cells rotate one place per cycle.
// Reset clears the count, the listing state and the result strobe; cell contents are kept.
// Results are strobed for one cycle and cannot be held off.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  deq_pkg::deq_in_t  item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output deq_pkg::deq_out_t result_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  deq_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              res_valid_q, res_valid_d;
  deq_pkg::deq_out_t res_q, res_d;
  deq_pkg::cell_op_e cell_op;
  logic              accept;
  logic              full;
  logic              empty;

  logic signed [deq_pkg::DataW-1:0] cell_data [DEPTH];

  assign accept = start_i && (state_q == deq_pkg::S_IDLE);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept && (item_i.func == deq_pkg::FN_LIST) && (count_q > CntW'(1))) begin
          state_d = deq_pkg::S_LIST;
        end
      end
      deq_pkg::S_LIST: begin
        if (rem_q == CntW'(1)) state_d = deq_pkg::S_IDLE;
      end
      default: state_d = deq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    rem_d       = rem_q;
    cell_op     = deq_pkg::OP_HOLD;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_d.last  = 1'b1;
          unique case (item_i.func) inside
            deq_pkg::FN_INS_FRONT, deq_pkg::FN_INS_REAR: begin
              if (full) begin
                res_d.status = deq_pkg::ST_FULL;
              end else begin
                res_d.status = deq_pkg::ST_DONE;
                count_d      = count_q + CntW'(1);
                cell_op      = (item_i.func == deq_pkg::FN_INS_FRONT) ?
                               deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR;
              end
            end
            deq_pkg::FN_DEL_FRONT, deq_pkg::FN_DEL_REAR: begin
              if (empty) begin
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                res_d.status = deq_pkg::ST_DONE;
                count_d      = count_q - CntW'(1);
                if (item_i.func == deq_pkg::FN_DEL_FRONT) cell_op = deq_pkg::OP_POP_FRONT;
              end
            end
            deq_pkg::FN_LIST: begin
              if (empty) begin
                res_d.status = deq_pkg::ST_EMPTY;
              end else begin
                res_d.status    = deq_pkg::ST_LISTED;
                res_d.value_out = cell_data[0];
                res_d.last      = (count_q == CntW'(1));
                cell_op         = deq_pkg::OP_ROTATE;
                rem_d           = count_q - CntW'(1);
              end
            end
            default: res_d.status = deq_pkg::ST_DONE;
          endcase
          res_d.fill = deq_pkg::FillW'(count_d);
        end
      end
      deq_pkg::S_LIST: begin
        res_valid_d     = 1'b1;
        res_d.status    = deq_pkg::ST_LISTED;
        res_d.value_out = cell_data[0];
        res_d.fill      = deq_pkg::FillW'(count_q);
        res_d.last      = (rem_q == CntW'(1));
        cell_op         = deq_pkg::OP_ROTATE;
        rem_d           = rem_q - CntW'(1);
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_pkg::cell_ctrl_t              ctrl;
    logic signed [deq_pkg::DataW-1:0] left;
    logic signed [deq_pkg::DataW-1:0] right;

    assign ctrl.op        = cell_op;
    assign ctrl.rear_slot = (count_q == CntW'(i));
    assign ctrl.tail      = (count_q == CntW'(i + 1));

    if (i == 0) begin : g_first
      assign left = item_i.value_in;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .ins_i  (item_i.value_in),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  assign busy_o         = (state_q == deq_pkg::S_LIST);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== test/deq_checker.sv =====
// Checker for the double-ended queue: mirrors the store, predicts each result and compares.
`timescale 1ns / 100ps

module deq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  deq_pkg::deq_in_t  item_i,
  input  logic              busy_o,
  input  logic              result_valid_o,
  input  deq_pkg::deq_out_t result_o,
  output int                fail_count_o,
  output int                pending_o
);
  import deq_pkg::*;

  logic signed [DataW-1:0] mirror_store [DEPTH];
  int unsigned             mirror_front;
  int unsigned             mirror_count;
  deq_out_t                replies_due [$];

  function automatic deq_out_t make_reply(status_e st, logic signed [DataW-1:0] v,
                                          int unsigned fill, logic last);
    deq_out_t r;
    r.status    = st;
    r.value_out = v;
    r.fill      = FillW'(fill);
    r.last      = last;
    return r;
  endfunction

  task automatic apply_deque_op(input deq_in_t it);
    int unsigned slot;
    int unsigned k;
    case (it.func)
      FN_INS_FRONT, FN_INS_REAR: begin
        if (mirror_count >= DEPTH) begin
          replies_due.push_back(make_reply(ST_FULL, '0, mirror_count, 1'b1));
        end else begin
          if (it.func == FN_INS_FRONT) begin
            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
            slot = mirror_front;
          end else begin
            slot = (mirror_front + mirror_count) % DEPTH;
          end
          mirror_store[slot] = it.value_in;
          mirror_count++;
          replies_due.push_back(make_reply(ST_DONE, '0, mirror_count, 1'b1));
        end
      end
      FN_DEL_FRONT, FN_DEL_REAR: begin
        if (mirror_count == 0) begin
          replies_due.push_back(make_reply(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          if (it.func == FN_DEL_FRONT) mirror_front = (mirror_front + 1) % DEPTH;
          mirror_count--;
          replies_due.push_back(make_reply(ST_DONE, '0, mirror_count, 1'b1));
        end
      end
      FN_LIST: begin
        if (mirror_count == 0) begin
          replies_due.push_back(make_reply(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (k = 0; k < mirror_count; k++) begin
            replies_due.push_back(make_reply(ST_LISTED,
                                             mirror_store[(mirror_front + k) % DEPTH],
                                             mirror_count, k + 1 == mirror_count));
          end
        end
      end
      default: begin
        replies_due.push_back(make_reply(ST_DONE, '0, mirror_count, 1'b1));
      end
    endcase
  endtask

  task automatic check_reply(input deq_out_t got);
    deq_out_t want;
    if (replies_due.size() == 0) begin
      $error("result with none due: status %0d value_out %0d fill %0d last %0d",
             got.status, got.value_out, got.fill, got.last);
      fail_count_o++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      fail_count_o++;
    end
    if (got.value_out !== want.value_out) begin
      $error("value_out: expected %0d, actual %0d", want.value_out, got.value_out);
      fail_count_o++;
    end
    if (got.fill !== want.fill) begin
      $error("fill: expected %0d, actual %0d", want.fill, got.fill);
      fail_count_o++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_front = 0;
      mirror_count = 0;
      replies_due.delete();
    end else begin
      if (result_valid_o === 1'b1) check_reply(result_o);
      if (start_i && busy_o === 1'b0) apply_deque_op(item_i);
    end
    pending_o = replies_due.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the double-ended queue testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import deq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int RandomOps = 500;
  localparam int IdlePct = 21;
  localparam int QuietFrom = 150;
  localparam int QuietTo = 280;
  localparam int DrainCycles = 40;
  localparam int TimeoutNs = 2_000_000;
  localparam logic [FuncW-1:0] FuncSpareLo = FuncW'(FN_LIST) + 1'b1;
  localparam logic [FuncW-1:0] FuncSpareHi = '1;
  localparam logic signed [DataW-1:0] ValMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] ValMax = {1'b0, {(DataW-1){1'b1}}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  deq_in_t   item_i = '0;
  logic      busy_o;
  logic      result_valid_o;
  deq_out_t  result_o;
  int        fail_count;
  int        pending;
  int        ops_issued = 0;

  always #6 clk_i = ~clk_i;

  double_ended_queue #(.DEPTH(Depth)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  deq_checker #(.DEPTH(Depth)) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Idle at random outside the quiet stretch, then hold the item until taken.
  task automatic issue_op(input logic [FuncW-1:0] f, input logic [DataW-1:0] v);
    deq_in_t it;
    it.func     = f;
    it.value_in = v;
    if (ops_issued < QuietFrom || ops_issued >= QuietTo) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    ops_issued++;
  endtask

  initial begin
    int k;
    int pick;
    int ins_pct;
    logic [FuncW-1:0] f;
    logic [DataW-1:0] v;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty store, spare codes, fill past full with corner values, list
    issue_op(FN_LIST, $urandom());
    issue_op(FN_DEL_FRONT, $urandom());
    issue_op(FN_DEL_REAR, $urandom());
    for (k = FuncSpareLo; k <= FuncSpareHi; k++) issue_op(FuncW'(k), $urandom());
    for (k = 0; k < Depth; k++) begin
      v = (k == 0) ? ValMin : (k == 1) ? ValMax : (k == 2) ? '0 : (k == 3) ? '1
          : $urandom();
      issue_op(k[0] ? FN_INS_REAR : FN_INS_FRONT, v);
    end
    issue_op(FN_INS_REAR, $urandom());
    issue_op(FN_INS_FRONT, $urandom());
    issue_op(FN_LIST, $urandom());

    // bursts that lean towards filling, draining or neither
    ins_pct = 50;
    for (k = 0; k < RandomOps; k++) begin
      if (k % 40 == 0) begin
        pick = $urandom_range(0, 2);
        ins_pct = (pick == 0) ? 80 : (pick == 1) ? 20 : 50;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        f = FuncW'($urandom_range(FuncSpareLo, FuncSpareHi));
      end else if (pick < 11) begin
        f = FN_LIST;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        f = $urandom_range(0, 1) ? FN_INS_REAR : FN_INS_FRONT;
      end else begin
        f = $urandom_range(0, 1) ? FN_DEL_REAR : FN_DEL_FRONT;
      end
      issue_op(f, $urandom());
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("FAIL");
    $finish;
  end

endmodule
